// File: rtl/core/assert_macros.svh
// assertion macros shared by the checker files
// needs signals named aclk and aresetn in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AST_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/mecm_pkg.sv
// shared constants and types of the mst edge component merger
// no dependencies
package mecm_pkg;

    // fixed field widths
    localparam int VTX_W       = 6;
    localparam int WEIGHT_BITS = 32;
    localparam int CNT_W       = 6;
    localparam int CFG_W       = 7;

    // default vertex storage depth
    localparam int MAX_VERTICES = 64;

    // saturation value of the tree-edge count
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // reset value of the vertex count register
    localparam logic [CFG_W-1:0] VC_RESET = 7'd64;

    // stream widths
    localparam int S_TDATA_W = 48;
    localparam int S_PAD_W   = S_TDATA_W - 2 * VTX_W - WEIGHT_BITS;
    localparam int M_TDATA_W = 56;
    localparam int M_PAD_W   = M_TDATA_W - 2 * VTX_W - WEIGHT_BITS - CNT_W;

    // operation codes
    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_EDGE  = 1'b1;

    // write strobes of the vertex store
    typedef struct packed {
        logic ent_we;
        logic nxt_we;
    } mem_ctl_t;

    // result status from the sequencer
    typedef struct packed {
        logic             fin;
        logic             accepted;
        logic             bad_vertex;
        logic [CNT_W-1:0] tree_edges;
    } res_t;

endpackage

// File: rtl/core/mecm_store.sv
// vertex store: label/head memory and next-member memory
// depends on mecm_pkg
module mecm_store #(
    parameter int MAX_VERTICES = mecm_pkg::MAX_VERTICES
) (
    input  logic                                      aclk,
    input  mecm_pkg::mem_ctl_t                        ctl,
    input  logic [$clog2(MAX_VERTICES)-1:0]           ent_waddr,
    input  logic [2*$clog2(MAX_VERTICES)-1:0]         ent_wdata,
    input  logic [$clog2(MAX_VERTICES)-1:0]           ent_raddr,
    output logic [2*$clog2(MAX_VERTICES)-1:0]         ent_rdata,
    input  logic [$clog2(MAX_VERTICES)-1:0]           nxt_waddr,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]         nxt_wdata,
    input  logic [$clog2(MAX_VERTICES)-1:0]           nxt_raddr,
    output logic [$clog2(MAX_VERTICES+1)-1:0]         nxt_rdata
);
    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int NXT_W = $clog2(MAX_VERTICES + 1);
    localparam int ENT_W = 2 * IDX_W;

    logic [ENT_W-1:0] ent_mem [MAX_VERTICES];
    logic [NXT_W-1:0] nxt_mem [MAX_VERTICES];
    logic [ENT_W-1:0] ent_rdata_reg;
    logic [NXT_W-1:0] nxt_rdata_reg;

    // head and label memory, one write and one registered read
    always_ff @(posedge aclk) begin
        if (ctl.ent_we) begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        ent_rdata_reg <= ent_mem[ent_raddr];
    end

    // next-member links, zero means no successor
    always_ff @(posedge aclk) begin
        if (ctl.nxt_we) begin
            nxt_mem[nxt_waddr] <= nxt_wdata;
        end
        nxt_rdata_reg <= nxt_mem[nxt_raddr];
    end

    assign ent_rdata = ent_rdata_reg;
    assign nxt_rdata = nxt_rdata_reg;

endmodule

// File: rtl/core/mecm_seq.sv
// sequencer: endpoint check, label compare, list walks and clearing sweep
// depends on mecm_pkg, drives mecm_store
module mecm_seq #(
    parameter int MAX_VERTICES = mecm_pkg::MAX_VERTICES
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic                                  op,
    input  logic [mecm_pkg::VTX_W-1:0]            src,
    input  logic [mecm_pkg::VTX_W-1:0]            dst,
    input  logic [mecm_pkg::CFG_W-1:0]            vertex_count,
    input  logic                                  out_free,
    output logic                                  ready,
    output mecm_pkg::res_t                        res,
    output mecm_pkg::mem_ctl_t                    ctl,
    output logic [$clog2(MAX_VERTICES)-1:0]       ent_waddr,
    output logic [2*$clog2(MAX_VERTICES)-1:0]     ent_wdata,
    output logic [$clog2(MAX_VERTICES)-1:0]       ent_raddr,
    input  logic [2*$clog2(MAX_VERTICES)-1:0]     ent_rdata,
    output logic [$clog2(MAX_VERTICES)-1:0]       nxt_waddr,
    output logic [$clog2(MAX_VERTICES+1)-1:0]     nxt_wdata,
    output logic [$clog2(MAX_VERTICES)-1:0]       nxt_raddr,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]     nxt_rdata
);
    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int NXT_W = $clog2(MAX_VERTICES + 1);
    localparam int CW    = (NXT_W > mecm_pkg::CFG_W) ? NXT_W : mecm_pkg::CFG_W;
    localparam logic [CW-1:0]    MAX_C    = CW'(MAX_VERTICES);
    localparam logic [NXT_W-1:0] MAX_N    = NXT_W'(MAX_VERTICES);
    localparam logic [NXT_W-1:0] LAST_N   = NXT_W'(MAX_VERTICES - 1);

    // state codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CHK  = 3'd1;
    localparam logic [2:0] ST_CLR  = 3'd2;
    localparam logic [2:0] ST_RDD  = 3'd3;
    localparam logic [2:0] ST_CMP  = 3'd4;
    localparam logic [2:0] ST_WLKA = 3'd5;
    localparam logic [2:0] ST_WLKT = 3'd6;
    localparam logic [2:0] ST_FIN  = 3'd7;

    logic [2:0]                 state_reg, state_next;
    logic [NXT_W-1:0]           step_reg, step_next;
    logic                       clr_op_reg, clr_op_next;
    logic                       acc_reg, acc_next;
    logic                       bad_reg, bad_next;
    logic [mecm_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0]           lab_s_reg, lab_s_next;
    logic [IDX_W-1:0]           head_s_reg, head_s_next;
    logic [IDX_W-1:0]           cur_reg, cur_next;
    logic [IDX_W-1:0]           abs_reg, abs_next;

    logic [CW-1:0]    lim;
    logic [CW-1:0]    src_ext;
    logic [CW-1:0]    dst_ext;
    logic             bad_now;
    logic [IDX_W-1:0] src_idx;
    logic [IDX_W-1:0] dst_idx;
    logic [IDX_W-1:0] ent_lab;
    logic [IDX_W-1:0] ent_head;
    logic [IDX_W-1:0] abs_pick;
    logic             nxt_ok;
    logic [NXT_W-1:0] nxt_dec;
    logic [IDX_W-1:0] nxt_idx;
    logic             step_more;

    // endpoint range check against the clamped vertex count
    always_comb begin
        lim     = (CW'(vertex_count) > MAX_C) ? MAX_C : CW'(vertex_count);
        src_ext = CW'(src);
        dst_ext = CW'(dst);
        bad_now = (src_ext >= lim) || (dst_ext >= lim);
        src_idx = src_ext[IDX_W-1:0];
        dst_idx = dst_ext[IDX_W-1:0];
    end

    // decode of the store read data
    always_comb begin
        ent_lab   = ent_rdata[IDX_W-1:0];
        ent_head  = ent_rdata[2*IDX_W-1:IDX_W];
        abs_pick  = (CW'(ent_head) >= MAX_C) ? dst_idx : ent_head;
        nxt_ok    = (nxt_rdata != '0) && (nxt_rdata <= MAX_N);
        nxt_dec   = nxt_rdata - NXT_W'(1);
        nxt_idx   = nxt_dec[IDX_W-1:0];
        step_more = step_reg < MAX_N;
    end

    // next-state and store access logic
    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        clr_op_next = clr_op_reg;
        acc_next    = acc_reg;
        bad_next    = bad_reg;
        cnt_next    = cnt_reg;
        lab_s_next  = lab_s_reg;
        head_s_next = head_s_reg;
        cur_next    = cur_reg;
        abs_next    = abs_reg;
        ctl         = '0;
        ent_waddr   = cur_reg;
        ent_wdata   = {head_s_reg, lab_s_reg};
        ent_raddr   = dst_idx;
        nxt_waddr   = cur_reg;
        nxt_wdata   = NXT_W'(abs_reg) + NXT_W'(1);
        nxt_raddr   = cur_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                acc_next  = 1'b0;
                bad_next  = 1'b0;
                ent_raddr = src_idx;
                if (op == mecm_pkg::OP_CLEAR) begin
                    clr_op_next = 1'b1;
                    step_next   = '0;
                    cnt_next    = '0;
                    state_next  = ST_CLR;
                end else if (bad_now) begin
                    bad_next   = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_RDD;
                end
            end
            ST_CLR: begin
                // one entry per cycle back to a singleton
                ctl.ent_we = 1'b1;
                ctl.nxt_we = 1'b1;
                ent_waddr  = step_reg[IDX_W-1:0];
                ent_wdata  = {step_reg[IDX_W-1:0], step_reg[IDX_W-1:0]};
                nxt_waddr  = step_reg[IDX_W-1:0];
                nxt_wdata  = '0;
                step_next  = step_reg + NXT_W'(1);
                if (step_reg == LAST_N) begin
                    state_next = clr_op_reg ? ST_FIN : ST_IDLE;
                end
            end
            ST_RDD: begin
                lab_s_next  = ent_lab;
                head_s_next = ent_head;
                ent_raddr   = dst_idx;
                state_next  = ST_CMP;
            end
            ST_CMP: begin
                if (ent_lab == lab_s_reg) begin
                    state_next = ST_FIN;
                end else begin
                    acc_next   = 1'b1;
                    if (cnt_reg != mecm_pkg::COUNT_MAX) begin
                        cnt_next = cnt_reg + mecm_pkg::CNT_W'(1);
                    end
                    abs_next   = abs_pick;
                    ctl.ent_we = 1'b1;
                    ent_waddr  = abs_pick;
                    nxt_raddr  = abs_pick;
                    step_next  = NXT_W'(1);
                    state_next = ST_WLKA;
                end
            end
            ST_WLKA: begin
                // relabel the absorbed list, one member per cycle
                if (step_more && nxt_ok) begin
                    ctl.ent_we = 1'b1;
                    ent_waddr  = nxt_idx;
                    nxt_raddr  = nxt_idx;
                    step_next  = step_reg + NXT_W'(1);
                end else begin
                    cur_next   = src_idx;
                    nxt_raddr  = src_idx;
                    step_next  = '0;
                    state_next = ST_WLKT;
                end
            end
            ST_WLKT: begin
                // find the source list tail, then link the absorbed list
                if (step_more && nxt_ok) begin
                    cur_next  = nxt_idx;
                    nxt_raddr = nxt_idx;
                    step_next = step_reg + NXT_W'(1);
                end else begin
                    ctl.nxt_we = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state, clearing sweep starts out of reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLR;
            step_reg   <= '0;
            clr_op_reg <= 1'b0;
            acc_reg    <= 1'b0;
            bad_reg    <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            clr_op_reg <= clr_op_next;
            acc_reg    <= acc_next;
            bad_reg    <= bad_next;
            cnt_reg    <= cnt_next;
        end
    end

    // working registers of a merge
    always_ff @(posedge aclk) begin
        lab_s_reg  <= lab_s_next;
        head_s_reg <= head_s_next;
        cur_reg    <= cur_next;
        abs_reg    <= abs_next;
    end

    assign ready          = (state_reg == ST_IDLE);
    assign res.fin        = (state_reg == ST_FIN);
    assign res.accepted   = acc_reg;
    assign res.bad_vertex = bad_reg;
    assign res.tree_edges = cnt_reg;

endmodule

// File: rtl/core/mst_edge_component_merger_core.sv
// Kruskal edge filter with linked-list component merging, one transfer at a time.
// Per item: check, then finish on a bad endpoint or sweep all entries on a clear. An edge reads
// and compares labels and finishes on a match, else walks k absorbed members and m source-list
// links (each <= MAX_VERTICES) first. m_tvalid is set in the same cycle that s_tready returns high,
// and a result the full output register cannot take holds s_tready low. Reset clears control state
// and runs the clearing sweep, s_tready low meanwhile. Depends on mecm_pkg, mecm_seq and mecm_store.
module mst_edge_component_merger_core #(
    parameter int MAX_VERTICES = mecm_pkg::MAX_VERTICES
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [mecm_pkg::CFG_W-1:0]       cfg_wr_data,  // vertex_count
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mecm_pkg::S_TDATA_W-1:0]   s_tdata,      // src_vertex, dst_vertex, edge_weight
    input  logic [0:0]                       s_tuser,      // operation
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mecm_pkg::M_TDATA_W-1:0]   m_tdata,      // out_src, out_dst, out_weight, tree_edges
    output logic [1:0]                       m_tuser       // accepted, bad_vertex
);
    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int NXT_W = $clog2(MAX_VERTICES + 1);
    localparam int VW    = mecm_pkg::VTX_W;
    localparam int WB    = mecm_pkg::WEIGHT_BITS;

    logic [mecm_pkg::CFG_W-1:0] vc_reg;
    logic                       op_reg;
    logic [VW-1:0]              src_reg;
    logic [VW-1:0]              dst_reg;
    logic [WB-1:0]              wgt_reg;
    logic                       m_tvalid_reg;
    logic [mecm_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [1:0]                 m_tuser_reg;

    logic                 in_xfer;
    logic                 out_free;
    logic                 seq_ready;
    mecm_pkg::res_t       res;
    mecm_pkg::mem_ctl_t   ctl;
    logic [IDX_W-1:0]     ent_waddr;
    logic [2*IDX_W-1:0]   ent_wdata;
    logic [IDX_W-1:0]     ent_raddr;
    logic [2*IDX_W-1:0]   ent_rdata;
    logic [IDX_W-1:0]     nxt_waddr;
    logic [NXT_W-1:0]     nxt_wdata;
    logic [IDX_W-1:0]     nxt_raddr;
    logic [NXT_W-1:0]     nxt_rdata;

    assign in_xfer  = s_tvalid && seq_ready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = seq_ready;

    // vertex count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= mecm_pkg::VC_RESET;
        end else if (cfg_wr_en) begin
            vc_reg <= cfg_wr_data;
        end
    end

    // input item capture
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            op_reg  <= s_tuser[0];
            src_reg <= s_tdata[VW-1:0];
            dst_reg <= s_tdata[2*VW-1:VW];
            wgt_reg <= s_tdata[2*VW+WB-1:2*VW];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res.fin && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.fin && out_free) begin
            m_tdata_reg <= {{mecm_pkg::M_PAD_W{1'b0}}, res.tree_edges, wgt_reg, dst_reg, src_reg};
            m_tuser_reg <= {res.bad_vertex, res.accepted};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    mecm_seq #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (in_xfer),
        .op           (op_reg),
        .src          (src_reg),
        .dst          (dst_reg),
        .vertex_count (vc_reg),
        .out_free     (out_free),
        .ready        (seq_ready),
        .res          (res),
        .ctl          (ctl),
        .ent_waddr    (ent_waddr),
        .ent_wdata    (ent_wdata),
        .ent_raddr    (ent_raddr),
        .ent_rdata    (ent_rdata),
        .nxt_waddr    (nxt_waddr),
        .nxt_wdata    (nxt_wdata),
        .nxt_raddr    (nxt_raddr),
        .nxt_rdata    (nxt_rdata)
    );

    mecm_store #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_store (
        .aclk      (aclk),
        .ctl       (ctl),
        .ent_waddr (ent_waddr),
        .ent_wdata (ent_wdata),
        .ent_raddr (ent_raddr),
        .ent_rdata (ent_rdata),
        .nxt_waddr (nxt_waddr),
        .nxt_wdata (nxt_wdata),
        .nxt_raddr (nxt_raddr),
        .nxt_rdata (nxt_rdata)
    );

endmodule

// File: rtl/core/mecm_chk.sv
// port-level checker for the merger core, attached by bind
// depends on mecm_pkg and assert_macros.svh
`include "assert_macros.svh"

module mecm_chk (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [mecm_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [1:0]                      m_tuser
);
    // stalled result holds
    `AST_NEXT(a_out_hold, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
    // a rejected endpoint never enters the tree
    `AST_IMPL(a_acc_not_bad, m_tvalid, !(m_tuser[0] && m_tuser[1]))
    // an accepted edge joins two different vertices
    `AST_IMPL(a_acc_no_loop, m_tvalid && m_tuser[0], m_tdata[5:0] != m_tdata[11:6])
    // one item at a time: busy right after an input transfer
    `AST_NEXT(a_busy_after_in, s_tvalid && s_tready, !s_tready)

endmodule

bind mst_edge_component_merger_core mecm_chk u_chk (.*);

// File: bench/mecm_edge_checker.sv
`timescale 1ns / 1ps
// result checker for the mst edge component merger: predicts one result per
// input transfer, edge or clear, and compares result transfers in order
// depends on mecm_pkg
module mecm_edge_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [mecm_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [mecm_pkg::S_TDATA_W-1:0] s_tdata,   // src_vertex, dst_vertex, edge_weight
    input  logic [0:0]                     s_tuser,   // operation
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [mecm_pkg::M_TDATA_W-1:0] m_tdata,   // out_src, out_dst, out_weight, tree_edges
    input  logic [1:0]                     m_tuser,   // accepted, bad_vertex
    output int                             error_count,
    output int                             outstanding
);
    typedef struct packed {
        logic                                    accepted;
        logic                                    bad_vertex;
        logic [mecm_pkg::VTX_W-1:0]              src;
        logic [mecm_pkg::VTX_W-1:0]              dst;
        logic signed [mecm_pkg::WEIGHT_BITS-1:0] weight;
        logic [mecm_pkg::CNT_W-1:0]              tree_edges;
    } edge_outcome_t;

    // forest model: component label, successor link (index plus one, zero = none)
    // and list head per vertex
    logic [mecm_pkg::VTX_W-1:0] comp_label [mecm_pkg::MAX_VERTICES];
    logic [mecm_pkg::VTX_W:0]   succ_link  [mecm_pkg::MAX_VERTICES];
    logic [mecm_pkg::VTX_W-1:0] list_lead  [mecm_pkg::MAX_VERTICES];
    logic [mecm_pkg::CNT_W-1:0] tree_count;
    logic [mecm_pkg::CFG_W-1:0] vertex_limit;

    edge_outcome_t pending_outcomes [$];

    initial begin
        error_count = 0;
        outstanding = 0;
    end

    // every vertex back to its own singleton component
    function automatic void restore_singletons();
        for (int v = 0; v < mecm_pkg::MAX_VERTICES; v++) begin
            comp_label[v] = mecm_pkg::VTX_W'(v);
            succ_link[v]  = '0;
            list_lead[v]  = mecm_pkg::VTX_W'(v);
        end
        tree_count = '0;
    endfunction

    // next list member, or MAX_VERTICES at the end of a list
    function automatic int successor(input int v);
        int n;
        if (v >= mecm_pkg::MAX_VERTICES)
            return mecm_pkg::MAX_VERTICES;
        n = succ_link[v];
        if (n == 0 || n > mecm_pkg::MAX_VERTICES)
            return mecm_pkg::MAX_VERTICES;
        return n - 1;
    endfunction

    // relabel the destination list to the source component, then append it
    // after the tail reached from the source vertex
    function automatic void absorb_component(input int s, input int d);
        logic [mecm_pkg::VTX_W-1:0] lab;
        logic [mecm_pkg::VTX_W-1:0] lead;
        int absorbed;
        int v;
        int tail;
        int n;
        int steps;
        lab      = comp_label[s];
        lead     = list_lead[s];
        absorbed = list_lead[d];
        v        = absorbed;
        steps    = 0;
        while (steps < mecm_pkg::MAX_VERTICES && v < mecm_pkg::MAX_VERTICES) begin
            comp_label[v] = lab;
            list_lead[v]  = lead;
            v = successor(v);
            steps++;
        end
        tail = s;
        for (steps = 0; steps < mecm_pkg::MAX_VERTICES; steps++) begin
            n = successor(tail);
            if (n >= mecm_pkg::MAX_VERTICES)
                break;
            tail = n;
        end
        succ_link[tail] = (mecm_pkg::VTX_W + 1)'(absorbed + 1);
    endfunction

    function automatic edge_outcome_t predict_edge_outcome(
        input logic                                    op,
        input logic [mecm_pkg::VTX_W-1:0]              s,
        input logic [mecm_pkg::VTX_W-1:0]              d,
        input logic signed [mecm_pkg::WEIGHT_BITS-1:0] w
    );
        edge_outcome_t res;
        int lim;
        lim = (vertex_limit > mecm_pkg::MAX_VERTICES) ? mecm_pkg::MAX_VERTICES
                                                      : int'(vertex_limit);
        res.accepted   = 1'b0;
        res.bad_vertex = 1'b0;
        res.src        = s;
        res.dst        = d;
        res.weight     = w;
        if (op == mecm_pkg::OP_CLEAR) begin
            restore_singletons();
        end else if (int'(s) >= lim || int'(d) >= lim) begin
            res.bad_vertex = 1'b1;
        end else if (comp_label[s] != comp_label[d]) begin
            absorb_component(s, d);
            res.accepted = 1'b1;
            if (tree_count != mecm_pkg::COUNT_MAX)
                tree_count = tree_count + 1'b1;
        end
        res.tree_edges = tree_count;
        return res;
    endfunction

    function automatic void compare_field(input string name, input longint want,
                                          input longint got);
        if (want != got) begin
            error_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // watch both channels and the register port
    always @(posedge aclk) begin
        edge_outcome_t want;
        edge_outcome_t got;
        if (!aresetn) begin
            restore_singletons();
            vertex_limit = mecm_pkg::VC_RESET;
            pending_outcomes.delete();
        end else begin
            if (cfg_wr_en)
                vertex_limit = cfg_wr_data;
            if (s_tvalid && s_tready)
                pending_outcomes.push_back(predict_edge_outcome(s_tuser[0],
                    s_tdata[mecm_pkg::VTX_W-1:0],
                    s_tdata[2*mecm_pkg::VTX_W-1:mecm_pkg::VTX_W],
                    s_tdata[2*mecm_pkg::VTX_W+mecm_pkg::WEIGHT_BITS-1:2*mecm_pkg::VTX_W]));
            if (m_tvalid && m_tready) begin
                got.accepted   = m_tuser[0];
                got.bad_vertex = m_tuser[1];
                got.src        = m_tdata[mecm_pkg::VTX_W-1:0];
                got.dst        = m_tdata[2*mecm_pkg::VTX_W-1:mecm_pkg::VTX_W];
                got.weight     = m_tdata[2*mecm_pkg::VTX_W+mecm_pkg::WEIGHT_BITS-1:
                                         2*mecm_pkg::VTX_W];
                got.tree_edges = m_tdata[2*mecm_pkg::VTX_W+mecm_pkg::WEIGHT_BITS+
                                         mecm_pkg::CNT_W-1:
                                         2*mecm_pkg::VTX_W+mecm_pkg::WEIGHT_BITS];
                if (pending_outcomes.size() == 0) begin
                    error_count++;
                    $error("result transfer with no edge outstanding");
                end else begin
                    want = pending_outcomes.pop_front();
                    compare_field("accepted", want.accepted, got.accepted);
                    compare_field("bad_vertex", want.bad_vertex, got.bad_vertex);
                    compare_field("out_src", want.src, got.src);
                    compare_field("out_dst", want.dst, got.dst);
                    compare_field("out_weight", want.weight, got.weight);
                    compare_field("tree_edges", want.tree_edges, got.tree_edges);
                end
            end
        end
        outstanding <= pending_outcomes.size();
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// top of the edge merger bench: clock, reset, edge stimulus with bursts and
// receiver stalls, verdict; depends on mecm_pkg, the core and mecm_edge_checker
module testbench;
    localparam int RUN_ITEMS    = 1050;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 2 * mecm_pkg::MAX_VERTICES + 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 200;

    logic                           aclk        = 1'b0;
    logic                           aresetn     = 1'b0;
    logic                           cfg_wr_en   = 1'b0;
    logic [mecm_pkg::CFG_W-1:0]     cfg_wr_data = '0;
    logic                           s_tvalid    = 1'b0;
    logic                           s_tready;
    logic [mecm_pkg::S_TDATA_W-1:0] s_tdata     = '0;   // src_vertex, dst_vertex, edge_weight
    logic [0:0]                     s_tuser     = '0;   // operation
    logic                           m_tvalid;
    logic                           m_tready    = 1'b0;
    logic [mecm_pkg::M_TDATA_W-1:0] m_tdata;            // out_src, out_dst, out_weight, tree_edges
    logic [1:0]                     m_tuser;            // accepted, bad_vertex

    int bench_errors;
    int outstanding;
    int results_seen = 0;
    int cycle_count  = 0;
    int items_sent   = 0;
    int burst_left   = 0;

    always #6 aclk = ~aclk;

    mst_edge_component_merger_core #(
        .MAX_VERTICES(mecm_pkg::MAX_VERTICES)
    ) u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    mecm_edge_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .error_count(bench_errors),
        .outstanding(outstanding)
    );

    // cycle limit and result count
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && m_tvalid && m_tready)
            results_seen <= results_seen + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // receiver: stall pattern changes in stretches, one long hold-off while edges arrive
    initial begin
        int mode;
        int left;
        logic hold_done;
        mode      = 0;
        left      = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_done && results_seen >= HOLD_AFTER && s_tvalid) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(16, 128);
                end
                left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (left % 3 != 0);
                endcase
            end
        end
    end

    // one edge or clear transfer, sent in bursts with random gaps
    task automatic offer_transfer(input logic op, input int src, input int dst,
                                  input logic signed [mecm_pkg::WEIGHT_BITS-1:0] w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {mecm_pkg::S_PAD_W'(0), w, mecm_pkg::VTX_W'(dst),
                     mecm_pkg::VTX_W'(src)};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // register write once every outstanding result is back
    task automatic program_vertex_count(input int value);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        cfg_wr_data <= mecm_pkg::CFG_W'(value);
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // one graph: clear, then mostly valid edges in ascending weight, some noise
    task automatic run_random_graph();
        int vc;
        int lim;
        int kind;
        int count;
        int s;
        int d;
        int r;
        int step;
        logic signed [mecm_pkg::WEIGHT_BITS-1:0] w;
        r = $urandom_range(0, 19);
        if (r < 8)       vc = 64;
        else if (r < 11) vc = $urandom_range(65, 127);
        else if (r < 15) vc = $urandom_range(2, 12);
        else if (r == 15) vc = 1;
        else if (r == 16) vc = 0;
        else             vc = $urandom_range(13, 63);
        program_vertex_count(vc);
        lim = (vc > mecm_pkg::MAX_VERTICES) ? mecm_pkg::MAX_VERTICES : vc;
        offer_transfer(mecm_pkg::OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                       $urandom);
        kind  = (lim >= 2) ? $urandom_range(0, 2) : 1;
        count = (kind != 1) ? lim - 1 : $urandom_range(5, 60);
        w = $urandom;
        if (w > 0)
            w = -w;
        for (int k = 0; k < count; k++) begin
            // ascending weights, occasionally out of order
            step = $urandom_range(0, 1 << 16);
            if ($urandom_range(0, 19) == 0)
                w = $urandom;
            else if (w > 32'sh7fff_ffff - step)
                w = 32'sh7fff_ffff;
            else
                w = w + step;
            r = $urandom_range(0, 99);
            if (r < 3) begin
                offer_transfer(mecm_pkg::OP_CLEAR, $urandom_range(0, 63),
                               $urandom_range(0, 63), w);
            end else if (r < 10) begin
                // endpoint outside the vertices in use, when fewer than MAX_VERTICES are in use
                s = $urandom_range(0, 63);
                d = $urandom_range(0, 63);
                if (lim < mecm_pkg::MAX_VERTICES) begin
                    if ($urandom_range(0, 1))
                        s = $urandom_range(lim, 63);
                    else
                        d = $urandom_range(lim, 63);
                end
                offer_transfer(mecm_pkg::OP_EDGE, s, d, w);
            end else if (kind == 1 || r < 25) begin
                s = (lim > 0) ? $urandom_range(0, lim - 1) : $urandom_range(0, 63);
                d = (lim > 0) ? $urandom_range(0, lim - 1) : $urandom_range(0, 63);
                offer_transfer(mecm_pkg::OP_EDGE, s, d, w);
            end else begin
                // spanning tree build: attach a fresh vertex to an earlier one
                s = $urandom_range(0, k);
                d = k + 1;
                if (kind == 0)
                    offer_transfer(mecm_pkg::OP_EDGE, s, d, w);
                else
                    offer_transfer(mecm_pkg::OP_EDGE, d, s, w);
            end
        end
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        // wait for the store sweep after reset
        do @(posedge aclk); while (!s_tready);
        program_vertex_count(64);

        // directed: extreme fields, self loop, same component, list merges
        offer_transfer(mecm_pkg::OP_CLEAR, 63, 63, 32'sh7fff_ffff);
        offer_transfer(mecm_pkg::OP_EDGE, 0, 63, 32'sh8000_0000);
        offer_transfer(mecm_pkg::OP_EDGE, 63, 0, -1);
        offer_transfer(mecm_pkg::OP_EDGE, 5, 5, 0);
        offer_transfer(mecm_pkg::OP_EDGE, 1, 2, 1);
        offer_transfer(mecm_pkg::OP_EDGE, 2, 3, 2);
        offer_transfer(mecm_pkg::OP_EDGE, 3, 1, 3);
        offer_transfer(mecm_pkg::OP_EDGE, 0, 3, 4);
        offer_transfer(mecm_pkg::OP_EDGE, 62, 61, 5);
        offer_transfer(mecm_pkg::OP_EDGE, 61, 2, 6);
        offer_transfer(mecm_pkg::OP_EDGE, 63, 62, 32'sh7fff_ffff);
        // vertex range limits
        program_vertex_count(10);
        offer_transfer(mecm_pkg::OP_EDGE, 9, 10, 7);
        offer_transfer(mecm_pkg::OP_EDGE, 10, 9, 8);
        offer_transfer(mecm_pkg::OP_EDGE, 63, 0, 9);
        offer_transfer(mecm_pkg::OP_EDGE, 9, 8, 10);
        program_vertex_count(0);
        offer_transfer(mecm_pkg::OP_EDGE, 0, 0, 11);
        program_vertex_count(127);
        offer_transfer(mecm_pkg::OP_EDGE, 63, 60, 12);
        offer_transfer(mecm_pkg::OP_EDGE, 4, 63, 13);
        program_vertex_count(1);
        offer_transfer(mecm_pkg::OP_EDGE, 0, 0, 14);
        offer_transfer(mecm_pkg::OP_EDGE, 0, 1, 15);
        offer_transfer(mecm_pkg::OP_CLEAR, 42, 21, 32'sh5555_aaaa);
        offer_transfer(mecm_pkg::OP_EDGE, 1, 0, 16);

        while (items_sent < RUN_ITEMS)
            run_random_graph();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (bench_errors == 0 && outstanding == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
